FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros for the glyph rasterizer. They expect clk and
// rst_n in scope; checks are off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop holds at every edge
`define TCGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// ante implies cons in the same cycle
`define TCGR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define TCGR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tcgr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text cell glyph rasterizer.
// ---------------------------------------------------------------------------
package tcgr_pkg;

  localparam logic [1:0] ACT_CELL_WR = 2'd0;
  localparam logic [1:0] ACT_FONT_WR = 2'd1;
  localparam logic [1:0] ACT_RENDER  = 2'd2;

  localparam int FONT_DEPTH = 4096;
  localparam int FONT_AW    = 12;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QLW    = 3;

  // Work item handed from front to back. For font writes, chr is the glyph byte.
  typedef struct packed {
    logic        is_font;
    logic [11:0] addr;
    logic [7:0]  chr;
    logic [3:0]  fg;
    logic [2:0]  bg;
    logic [6:0]  col;
    logic [4:0]  row;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RENDER
  } bk_state_t;

endpackage

FILE: sv/tcgr_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcgr_queue
// Short in-order queue of work items between the front and back ends.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcgr_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  tcgr_pkg::job_t            push_job,
  input  logic                      pop,
  output tcgr_pkg::job_t            head_job,
  output logic                      empty,
  output logic [tcgr_pkg::QLW-1:0]  level
);

  tcgr_pkg::job_t slot_r [tcgr_pkg::QDEPTH];

  logic [tcgr_pkg::QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tcgr_pkg::QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tcgr_pkg::QLW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + tcgr_pkg::QLW'(push) - tcgr_pkg::QLW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job = slot_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign level    = cnt_r;

  `TCGR_ASSERT_IMP(a_no_overflow, push, cnt_r != tcgr_pkg::QLW'(tcgr_pkg::QDEPTH), "queue overflow")
  `TCGR_ASSERT_IMP(a_no_underflow, pop, cnt_r != '0, "queue underflow")

endmodule

FILE: sv/tcgr_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcgr_front
// Command front end: cell store, post-reset clear, command decode, cell
// lookup for renders, and hand-off of font writes and renders to the queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcgr_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic [11:0]               in_address,
  input  logic [15:0]               in_data,
  input  logic [6:0]                in_column,
  input  logic [4:0]                in_row,
  input  logic [tcgr_pkg::QLW-1:0]  q_level,
  output logic                      push,
  output tcgr_pkg::job_t            push_job
);

  localparam int CELL_DEPTH = COLS * ROWS;
  localparam int CIW        = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

  logic [15:0] cell_mem [CELL_DEPTH];

  logic           clr_active_r, clr_active_nxt;
  logic [CIW-1:0] clr_addr_r, clr_addr_nxt;

  logic        s1_vld_r, s1_vld_nxt;
  logic        s1_font_r;
  logic [11:0] s1_addr_r;
  logic [7:0]  s1_byte_r;
  logic [6:0]  s1_col_r;
  logic [4:0]  s1_row_r;
  logic [15:0] cell_q_r;

  logic           accept;
  logic           in_screen;
  logic           cell_wr_en;
  logic [CIW-1:0] wr_idx;
  logic [15:0]    wr_data;
  logic           render_ok;
  logic           font_ok;
  logic [11:0]    rd_lin;

  assign busy = clr_active_r ||
                ((4'(q_level) + 4'(s1_vld_r)) >= 4'(tcgr_pkg::QDEPTH));

  assign accept    = start && !busy;
  assign in_screen = ({1'b0, in_column} < 8'(COLS)) && ({1'b0, in_row} < 6'(ROWS));
  assign render_ok = accept && (in_action == tcgr_pkg::ACT_RENDER) && in_screen;
  assign font_ok   = accept && (in_action == tcgr_pkg::ACT_FONT_WR);
  assign rd_lin    = 12'(int'(in_row) * COLS + int'(in_column));

  always_comb begin
    cell_wr_en = 1'b0;
    wr_idx     = in_address[CIW-1:0];
    wr_data    = in_data;
    if (clr_active_r) begin
      cell_wr_en = 1'b1;
      wr_idx     = clr_addr_r;
      wr_data    = '0;
    end else if (accept && (in_action == tcgr_pkg::ACT_CELL_WR) &&
                 ({1'b0, in_address} < 13'(CELL_DEPTH))) begin
      cell_wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_wr_en) begin
      cell_mem[wr_idx] <= wr_data;
    end
    if (render_ok) begin
      cell_q_r <= cell_mem[rd_lin[CIW-1:0]];
    end
  end

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == CIW'(CELL_DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
    s1_vld_nxt = render_ok || font_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_vld_r     <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      s1_vld_r     <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_font_r <= (in_action == tcgr_pkg::ACT_FONT_WR);
      s1_addr_r <= in_address;
      s1_byte_r <= in_data[7:0];
      s1_col_r  <= in_column;
      s1_row_r  <= in_row;
    end
  end

  always_comb begin
    push             = s1_vld_r;
    push_job.is_font = s1_font_r;
    push_job.addr    = s1_addr_r;
    push_job.chr     = s1_font_r ? s1_byte_r : cell_q_r[7:0];
    push_job.fg      = cell_q_r[11:8];
    push_job.bg      = cell_q_r[14:12];
    push_job.col     = s1_col_r;
    push_job.row     = s1_row_r;
  end

  `TCGR_ASSERT_IMP(a_clr_busy, clr_active_r, busy, "accepting during cell clear")
  `TCGR_ASSERT_IMP(a_push_src, s1_vld_r, $past(start && !busy), "push without accepted item")

endmodule

FILE: sv/tcgr_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcgr_back
// Back end: font store, font writes, and per-row glyph fetch, colour
// expansion and result output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcgr_back #(
  parameter int GLYPH_W = 8,
  parameter int GLYPH_H = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tcgr_pkg::job_t head_job,
  input  logic           empty,
  output logic           pop,
  output logic           out_strobe,
  output logic [8:0]     out_pixel_row,
  output logic [9:0]     out_pixel_column,
  output logic [31:0]    out_pixels,
  output logic           out_last
);

  localparam int YW         = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
  localparam int GLYPH_BITS = GLYPH_W * GLYPH_H;

  logic [7:0] font_mem [tcgr_pkg::FONT_DEPTH];

  tcgr_pkg::bk_state_t state_r, state_nxt;
  tcgr_pkg::job_t      job_r;
  logic [YW-1:0]       y_r, y_nxt;

  logic          font_we;
  logic          load;
  logic          issue;
  logic          y_end;

  logic [15:0]                   base_full;
  logic [tcgr_pkg::FONT_AW-1:0]  base;
  logic [6:0]                    bit_start;
  logic [tcgr_pkg::FONT_AW-1:0]  b0_addr;
  logic [tcgr_pkg::FONT_AW-1:0]  b1_addr;

  logic          st_vld_r;
  logic [7:0]    rd0_r, rd1_r;
  logic [2:0]    st_shift_r;
  logic [YW-1:0] st_y_r;
  logic          st_last_r;

  logic [15:0]   window;
  logic [31:0]   pix;

  logic          out_strobe_r;
  logic [8:0]    out_pixel_row_r;
  logic [9:0]    out_pixel_column_r;
  logic [31:0]   out_pixels_r;
  logic          out_last_r;

  assign y_end = (y_r == YW'(GLYPH_H - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcgr_pkg::BK_IDLE: begin
        if (!empty && !head_job.is_font) begin
          state_nxt = tcgr_pkg::BK_RENDER;
        end
      end
      tcgr_pkg::BK_RENDER: begin
        if (y_end) begin
          state_nxt = tcgr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = tcgr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    font_we = 1'b0;
    load    = 1'b0;
    issue   = 1'b0;
    case (state_r)
      tcgr_pkg::BK_IDLE: begin
        pop     = !empty;
        font_we = !empty && head_job.is_font;
        load    = !empty && !head_job.is_font;
      end
      tcgr_pkg::BK_RENDER: begin
        issue = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    y_nxt = y_r;
    if (load) begin
      y_nxt = '0;
    end else if (issue) begin
      y_nxt = y_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcgr_pkg::BK_IDLE;
      y_r          <= '0;
      st_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      y_r          <= y_nxt;
      st_vld_r     <= issue;
      out_strobe_r <= st_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= head_job;
    end
  end

  // glyph bit n of row y starts at y * GLYPH_W, counted from the glyph's base byte
  assign base_full = 16'(int'(job_r.chr) * GLYPH_BITS);
  assign base      = base_full[14:3];
  assign bit_start = 7'(int'(y_r) * GLYPH_W);
  assign b0_addr   = base + tcgr_pkg::FONT_AW'(bit_start[6:3]);
  assign b1_addr   = b0_addr + 1'b1;

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[head_job.addr] <= head_job.chr;
    end
    if (issue) begin
      rd0_r <= font_mem[b0_addr];
      rd1_r <= font_mem[b1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      st_shift_r <= bit_start[2:0];
      st_y_r     <= y_r;
      st_last_r  <= y_end;
    end
  end

  always_comb begin
    window = {rd1_r, rd0_r} >> st_shift_r;
    pix    = '0;
    for (int x = 0; x < 8; x++) begin
      if (x < GLYPH_W) begin
        pix[4*x +: 4] = window[x] ? job_r.fg : {1'b0, job_r.bg};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_vld_r) begin
      out_pixel_row_r    <= 9'(int'(job_r.row) * GLYPH_H + int'(st_y_r));
      out_pixel_column_r <= 10'(int'(job_r.col) * GLYPH_W);
      out_pixels_r       <= pix;
      out_last_r         <= st_last_r;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_pixel_row    = out_pixel_row_r;
  assign out_pixel_column = out_pixel_column_r;
  assign out_pixels       = out_pixels_r;
  assign out_last         = out_last_r;

  `TCGR_ASSERT_IMP(a_last_idle, st_vld_r && st_last_r, state_r == tcgr_pkg::BK_IDLE, "render did not end on last row")
  `TCGR_ASSERT_NXT(a_issue_feeds, issue, st_vld_r, "fetched row lost")

endmodule

FILE: sv/text_cell_glyph_rasterizer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_cell_glyph_rasterizer
// Text-mode character generator: cell store, font store and per-cell glyph
// rendering into rows of packed 4-bit colour indices.
// ---------------------------------------------------------------------------
// After reset the block clears its COLS*ROWS cell store, one entry per cycle,
// and holds busy high until the clear is done. A command is taken when start
// is high and busy is low. Cell writes finish in the cycle they are taken.
// Font writes and renders pass through a four-deep queue to the back end,
// which handles a font write in one idle step and a render in a load step
// and then one fetch per glyph row; that back end is the limit on sustained
// render rate. A render drives GLYPH_H results on consecutive cycles, each
// marked by out_strobe for one cycle, after the front-end register, queue,
// load, fetch and output registers; the receiver must take every result as it
// appears. busy also rises while the queue is full counting the item in the
// front-end register. Renders outside the screen and unused actions give nothing.
// ---------------------------------------------------------------------------

module text_cell_glyph_rasterizer #(
  parameter int COLS    = 80,
  parameter int ROWS    = 25,
  parameter int GLYPH_W = 8,
  parameter int GLYPH_H = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_address,
  input  logic [15:0] in_data,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_row,
  output logic        out_strobe,
  output logic [8:0]  out_pixel_row,
  output logic [9:0]  out_pixel_column,
  output logic [31:0] out_pixels,
  output logic        out_last
);

  logic                      push;
  tcgr_pkg::job_t            push_job;
  logic                      pop;
  tcgr_pkg::job_t            head_job;
  logic                      q_empty;
  logic [tcgr_pkg::QLW-1:0]  q_level;

  tcgr_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_address (in_address),
    .in_data    (in_data),
    .in_column  (in_column),
    .in_row     (in_row),
    .q_level    (q_level),
    .push       (push),
    .push_job   (push_job)
  );

  tcgr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .level    (q_level)
  );

  tcgr_back #(
    .GLYPH_W (GLYPH_W),
    .GLYPH_H (GLYPH_H)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_job         (head_job),
    .empty            (q_empty),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_column (out_pixel_column),
    .out_pixels       (out_pixels),
    .out_last         (out_last)
  );

endmodule

FILE: tb/text_cell_glyph_rasterizer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_cell_glyph_rasterizer_tb
// Self-checking bench for the text cell glyph rasterizer. A queue of cell
// writes, font writes and render commands feeds a clocked driver with random
// idle bursts. Each accepted item updates a local copy of the cell and font
// stores, and renders queue the glyph rows they should produce. A clocked
// monitor compares every strobed row with the oldest queued row. Glyphs are
// loaded before any cell that uses them is rendered.
// ---------------------------------------------------------------------------
module text_cell_glyph_rasterizer_tb;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int GLYPH_W     = 8;
  localparam int GLYPH_H     = 16;
  localparam int CELLS       = COLS * ROWS;
  localparam int GLYPH_BYTES = GLYPH_W * GLYPH_H / 8;
  localparam int N_ITEMS     = 320;
  localparam int STALL_LIMIT = 20000;
  localparam int MAX_PRINTS  = 40;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] address;
    logic [15:0] data;
    logic [6:0]  column;
    logic [4:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [8:0]  pixel_row;
    logic [9:0]  pixel_column;
    logic [31:0] pixels;
    logic        last;
  } glyph_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = '0;
  logic [11:0] in_address = '0;
  logic [15:0] in_data = '0;
  logic [6:0]  in_column = '0;
  logic [4:0]  in_row = '0;
  logic        out_strobe;
  logic [8:0]  out_pixel_row;
  logic [9:0]  out_pixel_column;
  logic [31:0] out_pixels;
  logic        out_last;

  cmd_t       cmd_q[$];
  glyph_row_t rows_due[$];
  cmd_t       cur_cmd;

  logic [15:0] cell_mem [CELLS];
  logic [7:0]  font_mem [tcgr_pkg::FONT_DEPTH];

  bit          font_set [tcgr_pkg::FONT_DEPTH];
  logic [7:0]  gen_chr [CELLS];
  int          recent_cells[$];
  int          n_queued;

  bit quiet;
  int idle_left;
  int errors;
  int stall_cycles;
  int n_taken;
  int n_renders;
  int n_rows;

  text_cell_glyph_rasterizer #(
    .COLS(COLS), .ROWS(ROWS), .GLYPH_W(GLYPH_W), .GLYPH_H(GLYPH_H)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_address(in_address), .in_data(in_data),
    .in_column(in_column), .in_row(in_row),
    .out_strobe(out_strobe), .out_pixel_row(out_pixel_row),
    .out_pixel_column(out_pixel_column), .out_pixels(out_pixels),
    .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic rasterize_cmd(input cmd_t c);
    logic [15:0] cell_word;
    logic [3:0]  fg;
    logic [3:0]  bg;
    int          base;
    int          n;
    logic [7:0]  gbyte;
    glyph_row_t  r;
    case (c.action)
      tcgr_pkg::ACT_CELL_WR: if (c.address < CELLS) cell_mem[c.address] = c.data;
      tcgr_pkg::ACT_FONT_WR: font_mem[c.address] = c.data[7:0];
      tcgr_pkg::ACT_RENDER: begin
        if (c.column < COLS && c.row < ROWS) begin
          cell_word = cell_mem[c.row * COLS + c.column];
          fg = cell_word[11:8];
          bg = {1'b0, cell_word[14:12]};
          base = cell_word[7:0] * GLYPH_W * GLYPH_H / 8;
          n_renders++;
          for (int y = 0; y < GLYPH_H; y++) begin
            r.pixels = '0;
            for (int x = 0; x < GLYPH_W; x++) begin
              n = y * GLYPH_W + x;
              gbyte = font_mem[(base + (n >> 3)) % tcgr_pkg::FONT_DEPTH];
              r.pixels[4*x +: 4] = gbyte[n % 8] ? fg : bg;
            end
            r.pixel_row = 9'(c.row * GLYPH_H + y);
            r.pixel_column = 10'(c.column * GLYPH_W);
            r.last = (y == GLYPH_H - 1);
            rows_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    bit took;
    took = start && !busy;
    if (took) begin
      rasterize_cmd(cur_cmd);
      n_taken++;
    end
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!start || took) begin
      if (took && !quiet && $urandom_range(0, 4) == 0) idle_left = $urandom_range(1, 13);
      if (idle_left > 0 || cmd_q.size() == 0) begin
        if (idle_left > 0) idle_left--;
        start <= 1'b0;
        in_action <= 2'($urandom);
        in_address <= 12'($urandom);
        in_data <= 16'($urandom);
        in_column <= 7'($urandom);
        in_row <= 5'($urandom);
      end else begin
        cur_cmd = cmd_q.pop_front();
        start <= 1'b1;
        in_action <= cur_cmd.action;
        in_address <= cur_cmd.address;
        in_data <= cur_cmd.data;
        in_column <= cur_cmd.column;
        in_row <= cur_cmd.row;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    glyph_row_t e;
    if (rst_n && out_strobe) begin
      if (rows_due.size() == 0) begin
        note_mismatch($sformatf("row %0d col %0d with nothing expected",
                                out_pixel_row, out_pixel_column));
      end else begin
        e = rows_due.pop_front();
        n_rows++;
        if (out_pixel_row !== e.pixel_row)
          note_mismatch($sformatf("pixel_row %0d, want %0d", out_pixel_row, e.pixel_row));
        if (out_pixel_column !== e.pixel_column)
          note_mismatch($sformatf("pixel_column %0d, want %0d (row %0d)",
                                  out_pixel_column, e.pixel_column, e.pixel_row));
        if (out_pixels !== e.pixels)
          note_mismatch($sformatf("pixels %h, want %h (row %0d col %0d)",
                                  out_pixels, e.pixels, e.pixel_row, e.pixel_column));
        if (out_last !== e.last)
          note_mismatch($sformatf("last %b, want %b (row %0d col %0d)",
                                  out_last, e.last, e.pixel_row, e.pixel_column));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [1:0] act, input logic [11:0] addr,
                           input logic [15:0] data, input logic [6:0] col,
                           input logic [4:0] row);
    cmd_t c;
    c = '{action: act, address: addr, data: data, column: col, row: row};
    cmd_q.push_back(c);
    n_queued++;
    case (act)
      tcgr_pkg::ACT_FONT_WR: font_set[addr] = 1'b1;
      tcgr_pkg::ACT_CELL_WR: begin
        if (addr < CELLS) begin
          gen_chr[addr] = data[7:0];
          recent_cells.push_back(int'(addr));
          if (recent_cells.size() > 16) void'(recent_cells.pop_front());
        end
      end
      default: ;
    endcase
  endtask

  task automatic load_glyph(input logic [7:0] chr);
    int a;
    for (int b = 0; b < GLYPH_BYTES; b++) begin
      a = chr * GLYPH_BYTES + b;
      if (!font_set[a])
        queue_cmd(tcgr_pkg::ACT_FONT_WR, 12'(a), 16'($urandom), 7'($urandom),
                  5'($urandom));
    end
  endtask

  task automatic render_at(input int col, input int row);
    if (col < COLS && row < ROWS) load_glyph(gen_chr[row * COLS + col]);
    queue_cmd(tcgr_pkg::ACT_RENDER, 12'($urandom), 16'($urandom), 7'(col), 5'(row));
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || start || rows_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int sub;
    int idx;
    int col;
    int row;
    bit mid_pause;
    logic [7:0] chr;
    logic [7:0] pool [8];
    pool = '{8'h00, 8'hFF, 8'h41, 8'h80, 8'h7F, 8'h01, 8'hAA, 8'h55};
    for (int i = 0; i < CELLS; i++) begin
      cell_mem[i] = '0;
      gen_chr[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: glyph 0 with edge patterns, corners, ignored writes, off-screen
    for (int b = 0; b < GLYPH_BYTES; b++) begin
      case (b % 4)
        0: chr = 8'h00;
        1: chr = 8'hFF;
        2: chr = 8'h01;
        default: chr = 8'h80;
      endcase
      queue_cmd(tcgr_pkg::ACT_FONT_WR, 12'(b), {8'hFF, chr}, 7'h7F, 5'h1F);
    end
    render_at(0, 0);
    queue_cmd(tcgr_pkg::ACT_CELL_WR, 12'(CELLS - 1), 16'hFF00, '0, '0);
    render_at(COLS - 1, ROWS - 1);
    queue_cmd(tcgr_pkg::ACT_CELL_WR, 12'(CELLS), 16'hFFFF, '0, '0);
    queue_cmd(tcgr_pkg::ACT_CELL_WR, 12'hFFF, 16'h1234, '0, '0);
    render_at(COLS, 0);
    render_at(0, ROWS);
    render_at(127, 31);
    queue_cmd(ACT_NONE, 12'hFFF, 16'hFFFF, 7'h7F, 5'h1F);
    queue_cmd(tcgr_pkg::ACT_CELL_WR, 12'd0, 16'h7000, '0, '0);
    render_at(0, 0);
    drain();

    mid_pause = 1'b0;
    while (n_queued < N_ITEMS) begin
      if (!mid_pause && n_queued >= N_ITEMS / 2) begin
        drain();
        mid_pause = 1'b1;
      end
      if (!quiet && n_queued >= N_ITEMS * 85 / 100) begin
        drain();
        quiet = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        chr = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] : 8'($urandom);
        if ($urandom_range(0, 9) != 0) idx = $urandom_range(0, CELLS - 1);
        else idx = $urandom_range(CELLS, 4095);
        queue_cmd(tcgr_pkg::ACT_CELL_WR, 12'(idx), {8'($urandom), chr}, 7'($urandom),
                  5'($urandom));
      end else if (pick < 45) begin
        queue_cmd(tcgr_pkg::ACT_FONT_WR, 12'($urandom), 16'($urandom), 7'($urandom),
                  5'($urandom));
      end else if (pick < 92) begin
        sub = $urandom_range(0, 9);
        if (sub < 6 && recent_cells.size() > 0) begin
          idx = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
          render_at(idx % COLS, idx / COLS);
        end else if (sub < 9) begin
          render_at($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1));
        end else begin
          if ($urandom_range(0, 1) != 0) begin
            col = $urandom_range(COLS, 127);
            row = $urandom_range(0, 31);
          end else begin
            col = $urandom_range(0, 127);
            row = $urandom_range(ROWS, 31);
          end
          render_at(col, row);
        end
      end else begin
        queue_cmd(ACT_NONE, 12'($urandom), 16'($urandom), 7'($urandom), 5'($urandom));
      end
    end

    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d items taken, %0d on-screen renders, %0d glyph rows checked",
             n_taken, n_renders, n_rows);
    $display("covered cell/font writes, ignored writes, off-screen renders, unused action");
    if (errors == 0 && rows_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/tcgr_pkg.sv
sv/tcgr_queue.sv
sv/tcgr_front.sv
sv/tcgr_back.sv
sv/text_cell_glyph_rasterizer.sv
tb/text_cell_glyph_rasterizer_tb.sv
